/* rtl/sfm_pkg.sv */
// Shared types and constants for the store-and-forward mailbox table.
// Depends on nothing; every rtl file but sfm_ram imports it.
package sfm_pkg;

  // Fixed field widths
  localparam int unsigned AddrW   = 32;
  localparam int unsigned TimeW   = 48;
  localparam int unsigned HandleW = 16;
  localparam int unsigned CntW    = 6;
  localparam int unsigned TtlW    = 32;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned CfgIdxW = 2;

  // Parameter defaults
  localparam int unsigned SlotsDef      = 32;
  localparam int unsigned HandleBitsDef = 16;

  // Most packets one retrieve may hand out
  localparam int unsigned OutCap = 32;

  // Register reset values
  localparam logic [CntW-1:0] SlotsInUseRst   = 6'd32;
  localparam logic [TtlW-1:0] TtlMsRst        = 32'd3600000;
  localparam logic [CntW-1:0] PerDestLimitRst = 6'd8;

  typedef enum logic [1:0] {
    OpStore    = 2'd0,
    OpRetrieve = 2'd1,
    OpExpire   = 2'd2,
    OpCount    = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSlotsInUse   = 2'd0,
    CfgTtlMs        = 2'd1,
    CfgPerDestLimit = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle   = 2'd0,
    StScan   = 2'd1,
    StFinish = 2'd2
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [AddrW-1:0]   dest_addr;
    logic [HandleW-1:0] packet_handle_in;
    logic [TimeW-1:0]   now_ms;
    logic [CntW-1:0]    max_take;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic               has_packet;
    logic [HandleW-1:0] packet_handle_out;
    logic [CntW-1:0]    addr_count;
    logic [CntW-1:0]    total_count;
    logic               last;
  } out_item_t;

  // Result handed from the scan engine to the output register
  typedef struct packed {
    logic      push;
    out_item_t item;
  } out_push_t;

endpackage

/* rtl/store_forward_mailbox_table_unit.sv */
// Store-and-forward mailbox table: one operation at a time, scanning slot RAM.
// The input stalls while an operation is in progress, so no new item is taken until the final
// result has entered the output register. The scan reads one slot of the slot RAM a cycle,
// except while a finished packet waits for a stalled output register.
// Reset: valid bits and control clear at once, registers take their reset values;
// slot RAM contents are not cleared and there is no clearing pass.
module store_forward_mailbox_table_unit #(
  parameter int unsigned SLOTS       = sfm_pkg::SlotsDef,
  parameter int unsigned HANDLE_BITS = sfm_pkg::HandleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sfm_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sfm_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [sfm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sfm_pkg::CfgW-1:0]      cfg_wdata_i
);
  import sfm_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned RamW = AddrW + TimeW + HANDLE_BITS;

  logic [CntW-1:0] slots_in_use_q;
  logic [TtlW-1:0] ttl_ms_q;
  logic [CntW-1:0] per_dest_limit_q;
  logic [CntW-1:0] lim;
  logic            busy, start, out_free;
  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  logic [RamW-1:0] ram_wdata, ram_rdata;
  out_push_t       out_push;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_in_use_q   <= SlotsInUseRst;
      ttl_ms_q         <= TtlMsRst;
      per_dest_limit_q <= PerDestLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSlotsInUse:   slots_in_use_q   <= cfg_wdata_i[CntW-1:0];
        CfgTtlMs:        ttl_ms_q         <= cfg_wdata_i[TtlW-1:0];
        CfgPerDestLimit: per_dest_limit_q <= cfg_wdata_i[CntW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Active limit: slots_in_use capped at the table size
  assign lim = ({1'b0, slots_in_use_q} < (CntW+1)'(SLOTS)) ? slots_in_use_q
                                                             : CntW'(SLOTS);

  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;

  sfm_scan #(
    .SLOTS       (SLOTS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (in_data_i),
    .lim_i       (lim),
    .ttl_i       (ttl_ms_q),
    .limit_i     (per_dest_limit_q),
    .busy_o      (busy),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_free_i  (out_free),
    .out_push_o  (out_push)
  );

  sfm_ram #(
    .Width (RamW),
    .Depth (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sfm_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (out_push),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/sfm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module sfm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sfm_out_stage.sv */
// Output holding register between the scan engine and the result channel.
// Depends on sfm_pkg.
module sfm_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfm_pkg::out_push_t push_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sfm_pkg::out_item_t out_data_o
);
  import sfm_pkg::*;

  logic      valid_q;
  out_item_t data_q;

  // Room for a new result when empty or when the held one transfers now
  assign free_o = !valid_q || !out_stall_i;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i.push) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      data_q <= push_i.item;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* rtl/sfm_scan.sv */
// Scan engine: walks the active slots through the slot RAM, keeps valid bits,
// counts, frees and hands out entries. Depends on sfm_pkg.
module sfm_scan #(
  parameter int unsigned SLOTS       = sfm_pkg::SlotsDef,
  parameter int unsigned HANDLE_BITS = sfm_pkg::HandleBitsDef,
  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned RamW = sfm_pkg::AddrW + sfm_pkg::TimeW + HANDLE_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  sfm_pkg::in_item_t           req_i,
  input  logic [sfm_pkg::CntW-1:0]    lim_i,
  input  logic [sfm_pkg::TtlW-1:0]    ttl_i,
  input  logic [sfm_pkg::CntW-1:0]    limit_i,
  output logic                        busy_o,
  output logic                        ram_we_o,
  output logic [IdxW-1:0]             ram_waddr_o,
  output logic [RamW-1:0]             ram_wdata_o,
  output logic                        ram_re_o,
  output logic [IdxW-1:0]             ram_raddr_o,
  input  logic [RamW-1:0]             ram_rdata_i,
  input  logic                        out_free_i,
  output sfm_pkg::out_push_t          out_push_o
);
  import sfm_pkg::*;

  state_e                 state_q, state_d;
  in_item_t               req_q, req_d;
  logic [CntW-1:0]        take_q, take_d;
  logic [CntW-1:0]        rd_cnt_q, rd_cnt_d;
  logic                   chk_vld_q, chk_vld_d;
  logic [IdxW-1:0]        chk_idx_q, chk_idx_d;
  logic [SLOTS-1:0]       valid_q, valid_d;
  logic [CntW-1:0]        dcnt_q, dcnt_d;
  logic [CntW-1:0]        tcnt_q, tcnt_d;
  logic [CntW-1:0]        taken_q, taken_d;
  logic                   free_found_q, free_found_d;
  logic [IdxW-1:0]        free_idx_q, free_idx_d;
  logic                   pend_vld_q, pend_vld_d;
  logic [HANDLE_BITS-1:0] pend_handle_q, pend_handle_d;

  logic [AddrW-1:0]       rd_dest;
  logic [TimeW-1:0]       rd_time;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic [TimeW-1:0]       age;
  logic                   slot_vld, dest_hit, stale, take_hit, hold, more, store_ok;

  // Split the slot word
  assign rd_dest   = ram_rdata_i[RamW-1 -: AddrW];
  assign rd_time   = ram_rdata_i[HANDLE_BITS +: TimeW];
  assign rd_handle = ram_rdata_i[HANDLE_BITS-1:0];

  // Evaluate the slot whose data the RAM presents this cycle
  assign slot_vld = chk_vld_q && valid_q[chk_idx_q];
  assign dest_hit = slot_vld && (rd_dest == req_q.dest_addr);
  assign age      = req_q.now_ms - rd_time;
  assign stale    = slot_vld && (age > TimeW'(ttl_i));
  assign take_hit = (req_q.op == OpRetrieve) && dest_hit && (taken_q < take_q);
  // Hold the scan while a finished packet waits for the output register
  assign hold     = take_hit && pend_vld_q && !out_free_i;
  assign more     = rd_cnt_q < lim_i;
  assign store_ok = free_found_q && (dcnt_q < limit_i);

  assign busy_o = (state_q != StIdle);

  // Next state, datapath and RAM control
  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    take_d        = take_q;
    rd_cnt_d      = rd_cnt_q;
    chk_vld_d     = chk_vld_q;
    chk_idx_d     = chk_idx_q;
    valid_d       = valid_q;
    dcnt_d        = dcnt_q;
    tcnt_d        = tcnt_q;
    taken_d       = taken_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    pend_vld_d    = pend_vld_q;
    pend_handle_d = pend_handle_q;
    ram_re_o      = 1'b0;
    ram_raddr_o   = rd_cnt_q[IdxW-1:0];
    ram_we_o      = 1'b0;
    ram_waddr_o   = free_idx_q;
    ram_wdata_o   = {req_q.dest_addr, req_q.now_ms, HANDLE_BITS'(req_q.packet_handle_in)};
    out_push_o    = '0;

    case (state_q)
      StIdle: begin
        if (start_i) begin
          req_d        = req_i;
          take_d       = (req_i.max_take > CntW'(OutCap)) ? CntW'(OutCap) : req_i.max_take;
          rd_cnt_d     = '0;
          chk_vld_d    = 1'b0;
          dcnt_d       = '0;
          tcnt_d       = '0;
          taken_d      = '0;
          free_found_d = 1'b0;
          pend_vld_d   = 1'b0;
          state_d      = StScan;
        end
      end

      StScan: begin
        if (!hold) begin
          // Issue the next read
          if (more) begin
            ram_re_o  = 1'b1;
            rd_cnt_d  = rd_cnt_q + 1'b1;
            chk_vld_d = 1'b1;
            chk_idx_d = rd_cnt_q[IdxW-1:0];
          end else begin
            chk_vld_d = 1'b0;
          end
          // Count
          if (slot_vld) begin
            tcnt_d = tcnt_q + 1'b1;
          end
          if (dest_hit) begin
            dcnt_d = dcnt_q + 1'b1;
          end
          // Track the lowest free slot
          if (chk_vld_q && !valid_q[chk_idx_q] && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = chk_idx_q;
          end
          // Hand out a match; the previous one is known not to be last
          if (take_hit) begin
            valid_d[chk_idx_q] = 1'b0;
            taken_d            = taken_q + 1'b1;
            if (pend_vld_q) begin
              out_push_o.push                   = 1'b1;
              out_push_o.item.has_packet        = 1'b1;
              out_push_o.item.packet_handle_out = HandleW'(pend_handle_q);
            end
            pend_vld_d    = 1'b1;
            pend_handle_d = rd_handle;
          end
          // Drop aged entries
          if ((req_q.op == OpExpire) && stale) begin
            valid_d[chk_idx_q] = 1'b0;
          end
          if (!more && !chk_vld_q) begin
            state_d = StFinish;
          end
        end
      end

      StFinish: begin
        if (out_free_i) begin
          out_push_o.push      = 1'b1;
          out_push_o.item.last = 1'b1;
          case (req_q.op)
            OpStore: begin
              out_push_o.item.status = !store_ok;
              if (store_ok) begin
                ram_we_o            = 1'b1;
                valid_d[free_idx_q] = 1'b1;
              end
            end
            OpRetrieve: begin
              out_push_o.item.has_packet        = pend_vld_q;
              out_push_o.item.packet_handle_out =
                pend_vld_q ? HandleW'(pend_handle_q) : '0;
            end
            OpCount: begin
              out_push_o.item.addr_count  = dcnt_q;
              out_push_o.item.total_count = tcnt_q;
            end
            default: begin
            end
          endcase
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      valid_q      <= '0;
      rd_cnt_q     <= '0;
      chk_vld_q    <= 1'b0;
      taken_q      <= '0;
      free_found_q <= 1'b0;
      pend_vld_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      rd_cnt_q     <= rd_cnt_d;
      chk_vld_q    <= chk_vld_d;
      taken_q      <= taken_d;
      free_found_q <= free_found_d;
      pend_vld_q   <= pend_vld_d;
    end
  end

  // Payload and counters
  always_ff @(posedge clk_i) begin
    req_q         <= req_d;
    take_q        <= take_d;
    chk_idx_q     <= chk_idx_d;
    dcnt_q        <= dcnt_d;
    tcnt_q        <= tcnt_d;
    free_idx_q    <= free_idx_d;
    pend_handle_q <= pend_handle_d;
  end

endmodule

/* rtl/sfm_checker.sv */
// Port-level assertions for the mailbox table, bound to the top level.
// Depends on sfm_pkg and store_forward_mailbox_table_unit.
module sfm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input sfm_pkg::in_item_t           in_data_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input sfm_pkg::out_item_t          out_data_o,
  input logic                        cfg_we_i,
  input logic [sfm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input logic [sfm_pkg::CfgW-1:0]    cfg_wdata_i
);
  import sfm_pkg::*;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // One item at a time: a transfer in closes the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in progress");

  // Only retrieved packets come before the final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.has_packet)
    else $error("non-final result without a packet");

  // A packet result carries no status or counts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.has_packet |->
      !out_data_o.status && out_data_o.addr_count == '0 && out_data_o.total_count == '0)
    else $error("packet result with status or counts");

  // A refused store carries nothing else
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.last && !out_data_o.has_packet)
    else $error("refusal mixed with other results");

endmodule

bind store_forward_mailbox_table_unit sfm_checker u_sfm_checker (.*);
